[hw/rtl/pstc_pkg.sv]
// Shared constants, types and the arctangent table of the scan converter.
package pstc_pkg;

    localparam int RANGE_BITS_DEF   = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_BITS  = 16;
    localparam int CIDX_BITS = 2;
    localparam int OUT_BITS  = 17;

    localparam logic [CIDX_BITS-1:0] CFG_START_ANGLE = 2'd0;
    localparam logic [CIDX_BITS-1:0] CFG_ANGLE_STEP  = 2'd1;
    localparam logic [CIDX_BITS-1:0] CFG_MIN_RANGE   = 2'd2;
    localparam logic [CIDX_BITS-1:0] CFG_MAX_RANGE   = 2'd3;

    localparam logic [CFG_BITS-1:0] MAX_RANGE_RST = 16'hFFFF;

    // 1/K of the CORDIC in Q16
    localparam logic [15:0] GAIN_Q16  = 16'd39797;
    localparam int          OUT_LIMIT = 65535;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic valid;
        logic flip;
    } t_pstc_ctl;

endpackage

[hw/rtl/pstc_beam_if.sv]
// Input channel: one range sample word per beam.
interface pstc_beam_if #(
    parameter int RANGE_BITS = pstc_pkg::RANGE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_sample;
    logic                  scan_start;
    logic                  no_return;

    modport source (output valid, output range_sample, output scan_start,
                    output no_return, input ready);
    modport sink   (input valid, input range_sample, input scan_start,
                    input no_return, output ready);
endinterface

[hw/rtl/pstc_point_if.sv]
// Output channel: one x,y point word.
interface pstc_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pstc_pkg::OUT_BITS-1:0] point_x;
    logic signed [pstc_pkg::OUT_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

[hw/rtl/pstc_cell.sv]
// One CORDIC rotation cell: a fixed shift and a fixed arctangent, registered.
module pstc_cell #(
    parameter int XW   = 34,
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  pstc_pkg::t_pstc_ctl   i_ctl,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [31:0]    i_z,
    output pstc_pkg::t_pstc_ctl   o_ctl,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [31:0]    o_z
);
    localparam logic signed [31:0] ATAN = pstc_pkg::ATAN_TURN[STEP];

    pstc_pkg::t_pstc_ctl   r_ctl;
    logic signed [XW-1:0]  r_x, n_x;
    logic signed [XW-1:0]  r_y, n_y;
    logic signed [31:0]    r_z, n_z;
    logic signed [XW-1:0]  w_dx, w_dy;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_comb begin
        if (!i_z[31]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
endmodule

[hw/rtl/polar_scan_to_cartesian_top.sv]
// Top level: beam angle tracking, range gating, CORDIC cell chain and point output.
//
// Each accepted range word takes the running beam angle (reloaded from
// start_angle when scan_start is set, advanced by angle_step after every
// word) and, if the range lies in [min_range, max_range] and no_return is
// clear, yields one x,y point in millimetres; otherwise it yields nothing.
// The word passes a multiply stage, a row of CORDIC_STEPS rotation cells and
// a rounding stage, each registered, before its point is presented. The whole
// chain advances together, one word per cycle, and halts only while the output
// register holds a point that is not taken. Configuration registers are to be
// written only while the chain is empty; the block itself does not enforce it.
module polar_scan_to_cartesian_top #(
    parameter int RANGE_BITS   = pstc_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS   = pstc_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = pstc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pstc_pkg::CIDX_BITS-1:0]    i_cfg_idx,
    input  logic [pstc_pkg::CFG_BITS-1:0]     i_cfg_data,
    pstc_beam_if.sink                         i_beam,
    pstc_point_if.source                      o_point
);
    localparam int XW = RANGE_BITS + 18;
    localparam int PW = RANGE_BITS + 16;
    localparam int CW = (RANGE_BITS > pstc_pkg::CFG_BITS) ? RANGE_BITS
                                                           : pstc_pkg::CFG_BITS;
    localparam int SW = XW + 1;

    logic [pstc_pkg::CFG_BITS-1:0] r_start_angle;
    logic [pstc_pkg::CFG_BITS-1:0] r_angle_step;
    logic [pstc_pkg::CFG_BITS-1:0] r_min_range;
    logic [pstc_pkg::CFG_BITS-1:0] r_max_range;
    logic [ANGLE_BITS-1:0]         r_beam_angle;

    logic                  w_adv;
    logic                  w_acc;
    logic                  w_keep;
    logic [ANGLE_BITS-1:0] w_ang;
    logic [31:0]           w_phase;
    logic                  w_flip;
    logic [PW-1:0]         w_prod;

    pstc_pkg::t_pstc_ctl   w_ctl [CORDIC_STEPS+1];
    logic signed [XW-1:0]  w_x   [CORDIC_STEPS+1];
    logic signed [XW-1:0]  w_y   [CORDIC_STEPS+1];
    logic signed [31:0]    w_z   [CORDIC_STEPS+1];

    pstc_pkg::t_pstc_ctl   r_ctl0;
    logic signed [XW-1:0]  r_x0;
    logic signed [31:0]    r_z0;

    logic                                  r_out_valid;
    logic signed [pstc_pkg::OUT_BITS-1:0]  r_out_x;
    logic signed [pstc_pkg::OUT_BITS-1:0]  r_out_y;

    function automatic logic signed [pstc_pkg::OUT_BITS-1:0] finish(
        input logic signed [XW-1:0] q,
        input logic                 flip
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] lim;
        s   = SW'(q) + SW'(32768);
        v   = s >>> 16;
        lim = SW'(pstc_pkg::OUT_LIMIT);
        if (flip) begin
            v = -v;
        end
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v[pstc_pkg::OUT_BITS-1:0];
    endfunction

    assign w_adv = !r_out_valid || o_point.ready;
    assign w_acc = i_beam.valid && w_adv;
    assign i_beam.ready = w_adv;

    assign w_ang   = i_beam.scan_start ? ANGLE_BITS'(r_start_angle) : r_beam_angle;
    assign w_keep  = !i_beam.no_return
                     && (CW'(i_beam.range_sample) >= CW'(r_min_range))
                     && (CW'(i_beam.range_sample) <= CW'(r_max_range));
    assign w_phase = 32'(w_ang) << (32 - ANGLE_BITS);
    assign w_flip  = w_phase[31] ^ w_phase[30];
    assign w_prod  = i_beam.range_sample * PW'(pstc_pkg::GAIN_Q16);

    // configuration and beam angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_angle_step  <= '0;
            r_min_range   <= '0;
            r_max_range   <= pstc_pkg::MAX_RANGE_RST;
            r_beam_angle  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pstc_pkg::CFG_START_ANGLE: r_start_angle <= i_cfg_data;
                    pstc_pkg::CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
                    pstc_pkg::CFG_MIN_RANGE:   r_min_range   <= i_cfg_data;
                    pstc_pkg::CFG_MAX_RANGE:   r_max_range   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_beam_angle <= w_ang + ANGLE_BITS'(r_angle_step);
            end
        end
    end

    // entry stage: gain multiply, quadrant fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_adv) begin
            r_ctl0.valid <= w_acc && w_keep;
            r_ctl0.flip  <= w_flip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x0 <= XW'(w_prod);
            r_z0 <= {w_phase[31] ^ w_flip, w_phase[30:0]};
        end
    end

    assign w_ctl[0] = r_ctl0;
    assign w_x[0]   = r_x0;
    assign w_y[0]   = '0;
    assign w_z[0]   = r_z0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        pstc_cell #(
            .XW   (XW),
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_ctl[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x <= finish(w_x[CORDIC_STEPS], w_ctl[CORDIC_STEPS].flip);
            r_out_y <= finish(w_y[CORDIC_STEPS], w_ctl[CORDIC_STEPS].flip);
        end
    end

    assign o_point.valid   = r_out_valid;
    assign o_point.point_x = r_out_x;
    assign o_point.point_y = r_out_y;

endmodule
